// ===== rtl/two_channel_fir_convolver_assert.svh =====
// Assertion macros for the two-channel FIR convolver.
// Used by the checker that is bound to the top level; needs no other file.
`ifndef TWO_CHANNEL_FIR_CONVOLVER_ASSERT_SVH
`define TWO_CHANNEL_FIR_CONVOLVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TCFC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TCFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tcfc_pkg.sv =====
// Shared types and constants of the two-channel FIR convolver.
// Has no dependencies; the store, multiply-accumulate unit, sequencer, top level, checker and testbench import it.
`default_nettype none

package tcfc_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 18;
  localparam int FRAC_BITS = 17;
  localparam int PROD_W    = SAMPLE_W + COEF_W;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  // Request function codes.
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;

  // Channel counts at or below this value select mono operation.
  localparam logic [1:0] CH_COUNT_MONO  = 2'd1;
  localparam logic [1:0] CH_COUNT_RESET = 2'd2;

  // Write controls from the sequencer to the coefficient and delay stores.
  typedef struct packed {
    logic       clear;
    logic       coef_we;
    logic [1:0] dly_we;
  } store_ctrl_t;

  // Controls from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic start;
    logic issue;
    logic last;
  } mac_ctrl_t;

  // Finished result from the multiply-accumulate unit.
  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sat;
  } mac_res_t;

endpackage

`default_nettype wire

// ===== rtl/tcfc_in_if.sv =====
// Input request channel of the two-channel FIR convolver.
// Depends on nothing; carries valid, ready and the request fields.
`default_nettype none

interface tcfc_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic               channel;
  logic signed [23:0] sample_in;
  logic [8:0]         tap_index;
  logic signed [17:0] tap_value;

  modport source (output valid, func, channel, sample_in, tap_index, tap_value,
                  input ready);
  modport sink (input valid, func, channel, sample_in, tap_index, tap_value,
                output ready);
  modport monitor (input valid, ready, func, channel, sample_in, tap_index,
                   tap_value);
endinterface

`default_nettype wire

// ===== rtl/tcfc_out_if.sv =====
// Result channel of the two-channel FIR convolver.
// Depends on nothing; carries valid, ready and the result fields.
`default_nettype none

interface tcfc_out_if;
  logic               valid;
  logic               ready;
  logic               channel_out;
  logic signed [23:0] sample_out;
  logic               copy_to_both;
  logic               saturated;

  modport source (output valid, channel_out, sample_out, copy_to_both, saturated,
                  input ready);
  modport sink (input valid, channel_out, sample_out, copy_to_both, saturated,
                output ready);
  modport monitor (input valid, ready, channel_out, sample_out, copy_to_both,
                   saturated);
endinterface

`default_nettype wire

// ===== rtl/tcfc_store.sv =====
// Coefficient store and the two per-channel delay lines, one write and one
// registered read port each. Depends on tcfc_pkg.
`default_nettype none

module tcfc_store
  import tcfc_pkg::*;
#(
  parameter int TAPS = 512
) (
  input  wire logic                       clk,
  input  wire store_ctrl_t                ctrl,
  input  wire logic [$clog2(TAPS)-1:0]    coef_waddr,
  input  wire logic signed [COEF_W-1:0]   coef_wdata,
  input  wire logic [$clog2(TAPS)-1:0]    dly_waddr,
  input  wire logic signed [SAMPLE_W-1:0] dly_wdata,
  input  wire logic [$clog2(TAPS)-1:0]    coef_raddr,
  input  wire logic [$clog2(TAPS)-1:0]    dly_raddr,
  input  wire logic                       dly_sel,
  output logic signed [COEF_W-1:0]        coef_q,
  output logic signed [SAMPLE_W-1:0]      dly_q
);

  logic signed [COEF_W-1:0]   coef_mem [TAPS];
  logic signed [SAMPLE_W-1:0] dly0_mem [TAPS];
  logic signed [SAMPLE_W-1:0] dly1_mem [TAPS];
  logic signed [SAMPLE_W-1:0] dly0_q;
  logic signed [SAMPLE_W-1:0] dly1_q;
  logic signed [COEF_W-1:0]   coef_wval;
  logic signed [SAMPLE_W-1:0] dly_wval;

  // The clearing pass writes zeros through the normal write ports.
  assign coef_wval = ctrl.clear ? '0 : coef_wdata;
  assign dly_wval  = ctrl.clear ? '0 : dly_wdata;

  // Coefficient memory.
  always_ff @(posedge clk) begin
    if (ctrl.coef_we) begin
      coef_mem[coef_waddr] <= coef_wval;
    end
    coef_q <= coef_mem[coef_raddr];
  end

  // Left channel delay line.
  always_ff @(posedge clk) begin
    if (ctrl.dly_we[0]) begin
      dly0_mem[dly_waddr] <= dly_wval;
    end
    dly0_q <= dly0_mem[dly_raddr];
  end

  // Right channel delay line.
  always_ff @(posedge clk) begin
    if (ctrl.dly_we[1]) begin
      dly1_mem[dly_waddr] <= dly_wval;
    end
    dly1_q <= dly1_mem[dly_raddr];
  end

  assign dly_q = dly_sel ? dly1_q : dly0_q;

endmodule

`default_nettype wire

// ===== rtl/tcfc_mac.sv =====
// Shared multiply-accumulate unit with rounding and saturation of the sum.
// Depends on tcfc_pkg.
`default_nettype none

module tcfc_mac
  import tcfc_pkg::*;
#(
  parameter int TAPS = 512
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire mac_ctrl_t                  ctrl,
  input  wire logic signed [COEF_W-1:0]   coef_q,
  input  wire logic signed [SAMPLE_W-1:0] dly_q,
  output mac_res_t                        res
);

  localparam int ACC_W = PROD_W + $clog2(TAPS) + 1;
  localparam int Y_W   = ACC_W - FRAC_BITS;

  logic                     v1, l1, v2, l2, l3;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [Y_W-1:0]    y;
  logic                     y_sat;
  logic signed [SAMPLE_W-1:0] y_clip;
  logic                       done_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       sat_r;

  // Pipeline markers: read data, product, then final sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      l1     <= 1'b0;
      v2     <= 1'b0;
      l2     <= 1'b0;
      l3     <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1     <= ctrl.issue;
      l1     <= ctrl.issue & ctrl.last;
      v2     <= v1;
      l2     <= l1;
      l3     <= l2;
      done_r <= l3;
    end
  end

  // Multiplier stage, registered before the accumulator.
  always_ff @(posedge clk) begin
    prod <= PROD_W'(coef_q) * PROD_W'(dly_q);
  end

  // Accumulator, cleared when a new sample starts.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Round half up, drop the fraction, then clip to the sample range.
  assign rnd    = acc + (ACC_W'(1) << (FRAC_BITS - 1));
  assign y      = rnd[ACC_W-1:FRAC_BITS];
  assign y_sat  = !((&y[Y_W-1:SAMPLE_W-1]) || !(|y[Y_W-1:SAMPLE_W-1]));
  assign y_clip = !y_sat ? y[SAMPLE_W-1:0] :
                  (y[Y_W-1] ? SAMPLE_MIN : SAMPLE_MAX);

  always_ff @(posedge clk) begin
    if (l3) begin
      sample_r <= y_clip;
      sat_r    <= y_sat;
    end
  end

  assign res = '{done: done_r, sample: sample_r, sat: sat_r};

endmodule

`default_nettype wire

// ===== rtl/tcfc_seq.sv =====
// Sequencer: request handshake, clearing pass, tap sweep, write positions,
// channel count register and the result register. Depends on tcfc_pkg and
// the two channel interfaces.
`default_nettype none

module tcfc_seq
  import tcfc_pkg::*;
#(
  parameter int TAPS = 512
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  tcfc_in_if.sink                       din,
  tcfc_out_if.source                    dout,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_wdata,
  output store_ctrl_t                   st_ctrl,
  output logic [$clog2(TAPS)-1:0]       coef_waddr,
  output logic [$clog2(TAPS)-1:0]       dly_waddr,
  output logic [$clog2(TAPS)-1:0]       coef_raddr,
  output logic [$clog2(TAPS)-1:0]       dly_raddr,
  output logic                          dly_sel,
  output mac_ctrl_t                     mc_ctrl,
  input  wire mac_res_t                 mc_res
);

  localparam int AW = $clog2(TAPS);
  localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_WAIT,
    S_RESULT
  } state_t;

  state_t                     state;
  logic [AW-1:0]              clr_cnt;
  logic [AW-1:0]              k;
  logic [AW-1:0]              j;
  logic                       ch;
  logic                       mono_r;
  logic [AW-1:0]              wpos [2];
  logic [1:0]                 chan_count;
  logic                       out_valid;
  logic                       out_channel;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_copy;
  logic                       out_sat;

  logic          take;
  logic          mono;
  logic          run_start;
  logic          load_ok;
  logic          out_load;
  logic [AW-1:0] pos;

  // Request decode.
  assign din.ready = (state == S_IDLE);
  assign take      = din.valid && din.ready;
  assign mono      = (chan_count <= CH_COUNT_MONO);
  assign run_start = take && (din.func == FUNC_SAMPLE) && !(mono && din.channel);
  assign load_ok   = take && (din.func == FUNC_LOAD) && (int'(din.tap_index) < TAPS);
  assign pos       = wpos[din.channel];
  assign out_load  = (state == S_RESULT) && (!out_valid || dout.ready);

  // Store write and read controls.
  assign st_ctrl.clear   = (state == S_CLEAR);
  assign st_ctrl.coef_we = st_ctrl.clear || load_ok;
  assign st_ctrl.dly_we  = st_ctrl.clear ? 2'b11 :
                           (run_start ? (din.channel ? 2'b10 : 2'b01) : 2'b00);
  assign coef_waddr = st_ctrl.clear ? clr_cnt : AW'(din.tap_index);
  assign dly_waddr  = st_ctrl.clear ? clr_cnt : pos;
  assign coef_raddr = k;
  assign dly_raddr  = j;
  assign dly_sel    = ch;

  // Multiply-accumulate controls.
  assign mc_ctrl.start = run_start;
  assign mc_ctrl.issue = (state == S_RUN);
  assign mc_ctrl.last  = (k == LAST);

  // Result channel.
  assign dout.valid        = out_valid;
  assign dout.channel_out  = out_channel;
  assign dout.sample_out   = out_sample;
  assign dout.copy_to_both = out_copy;
  assign dout.saturated    = out_sat;

  // State, counters, positions, configuration and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      wpos[0]    <= '0;
      wpos[1]    <= '0;
      chan_count <= CH_COUNT_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        chan_count <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (run_start) begin
            ch                <= din.channel;
            mono_r            <= mono;
            j                 <= pos;
            k                 <= '0;
            wpos[din.channel] <= (pos == LAST) ? '0 : pos + 1'b1;
            state             <= S_RUN;
          end
        end
        S_RUN: begin
          k <= k + 1'b1;
          j <= (j == '0) ? LAST : j - 1'b1;
          if (k == LAST) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (mc_res.done) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload, loaded when the result register is free.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_channel <= ch;
      out_sample  <= mc_res.sample;
      out_copy    <= mono_r;
      out_sat     <= mc_res.sat;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/two_channel_fir_convolver.sv =====
// Top level of the two-channel FIR convolver: sequencer, stores and the
// shared multiply-accumulate unit. Depends on tcfc_pkg, the channel
// interfaces, tcfc_store, tcfc_mac and tcfc_seq.
//
// A load request writes one coefficient tap and does not make the block busy.
// A sample request is written into its channel's delay line and then filtered
// by one multiply-accumulate unit that handles one tap per cycle; the block
// takes no further request until the finished result has moved into an output
// register, where it waits for the receiver. After reset the block zeroes the
// coefficient store and both delay lines; no request is accepted while it does
// so, although channel_count writes are taken. In mono mode right channel
// samples are dropped without a result and left channel results carry
// copy_to_both.
`default_nettype none

module two_channel_fir_convolver
  import tcfc_pkg::*;
#(
  parameter int TAPS = 512
) (
  input  wire logic       clk,
  input  wire logic       rst,
  tcfc_in_if.sink         din,
  tcfc_out_if.source      dout,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata
);

  localparam int AW = $clog2(TAPS);

  store_ctrl_t                st_ctrl;
  mac_ctrl_t                  mc_ctrl;
  mac_res_t                   mc_res;
  logic [AW-1:0]              coef_waddr;
  logic [AW-1:0]              dly_waddr;
  logic [AW-1:0]              coef_raddr;
  logic [AW-1:0]              dly_raddr;
  logic                       dly_sel;
  logic signed [COEF_W-1:0]   coef_q;
  logic signed [SAMPLE_W-1:0] dly_q;

  // Control and handshake.
  tcfc_seq #(.TAPS(TAPS)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .din        (din),
    .dout       (dout),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .st_ctrl    (st_ctrl),
    .coef_waddr (coef_waddr),
    .dly_waddr  (dly_waddr),
    .coef_raddr (coef_raddr),
    .dly_raddr  (dly_raddr),
    .dly_sel    (dly_sel),
    .mc_ctrl    (mc_ctrl),
    .mc_res     (mc_res)
  );

  // Coefficients and delay lines.
  tcfc_store #(.TAPS(TAPS)) u_store (
    .clk        (clk),
    .ctrl       (st_ctrl),
    .coef_waddr (coef_waddr),
    .coef_wdata (din.tap_value),
    .dly_waddr  (dly_waddr),
    .dly_wdata  (din.sample_in),
    .coef_raddr (coef_raddr),
    .dly_raddr  (dly_raddr),
    .dly_sel    (dly_sel),
    .coef_q     (coef_q),
    .dly_q      (dly_q)
  );

  // Shared multiply-accumulate unit.
  tcfc_mac #(.TAPS(TAPS)) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mc_ctrl),
    .coef_q (coef_q),
    .dly_q  (dly_q),
    .res    (mc_res)
  );

endmodule

`default_nettype wire

// ===== rtl/tcfc_checker.sv =====
// Port-level checker for the two-channel FIR convolver and its bind.
// Depends on tcfc_pkg, the channel interfaces and the assertion macro header.
`default_nettype none

`include "two_channel_fir_convolver_assert.svh"

module tcfc_checker
  import tcfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  tcfc_in_if.sink         din,
  tcfc_out_if.source      dout,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata
);

  logic [1:0] cnt_q;
  logic       mono_q;

  // Shadow copy of the channel count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_q <= CH_COUNT_RESET;
    end else if (cfg_we) begin
      cnt_q <= cfg_wdata;
    end
  end

  assign mono_q = (cnt_q <= CH_COUNT_MONO);

  // The stores are being cleared straight after reset.
  `TCFC_ASSERT_IMPL(a_busy_after_reset, clk, rst, $fell(rst), !din.ready, "ready during clearing pass")

  // A sample that is filtered keeps the block busy in the next cycle.
  `TCFC_ASSERT_NEXT(a_busy_after_sample, clk, rst, din.valid && din.ready && din.func == FUNC_SAMPLE && !(mono_q && din.channel), !din.ready, "ready straight after a sample")

  // A waiting result holds its value.
  `TCFC_ASSERT_NEXT(a_result_holds, clk, rst, dout.valid && !dout.ready, dout.valid && $stable(dout.sample_out), "result dropped or changed while stalled")

  // The copy flag follows the channel mode.
  `TCFC_ASSERT_IMPL(a_copy_flag, clk, rst, dout.valid, dout.copy_to_both == mono_q, "copy flag does not match mode")

  // A clipped result sits on one of the rails.
  `TCFC_ASSERT_IMPL(a_sat_rail, clk, rst, dout.valid && dout.saturated, (dout.sample_out == SAMPLE_MAX) || (dout.sample_out == SAMPLE_MIN), "clipped result off the rail")

endmodule

bind two_channel_fir_convolver tcfc_checker u_tcfc_checker (
  .clk       (clk),
  .rst       (rst),
  .din       (din),
  .dout      (dout),
  .cfg_we    (cfg_we),
  .cfg_wdata (cfg_wdata)
);

`default_nettype wire

// ===== tb/tb_two_channel_fir_convolver.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the two-channel FIR convolver.
// Depends on tcfc_pkg, tcfc_in_if, tcfc_out_if and two_channel_fir_convolver.

module tb_two_channel_fir_convolver;
  import tcfc_pkg::*;

  localparam int TAPS         = 512;
  localparam int DRAIN_CYCLES = TAPS + 64;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int LONG_HOLD    = 4000;
  localparam int PHASE_ITEMS  = 196;

  typedef struct {
    logic               func;
    logic               channel;
    logic signed [23:0] sample_in;
    logic [8:0]         tap_index;
    logic signed [17:0] tap_value;
  } fir_req_t;

  typedef struct {
    logic               channel_out;
    logic signed [23:0] sample_out;
    logic               copy_to_both;
    logic               saturated;
  } fir_res_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_wdata;

  tcfc_in_if  req_if ();
  tcfc_out_if res_if ();

  two_channel_fir_convolver #(
    .TAPS(TAPS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .din      (req_if),
    .dout     (res_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Mirror of the filter state, kept in step with every accepted request.
  logic signed [COEF_W-1:0]   tap_coef [TAPS];
  logic signed [SAMPLE_W-1:0] history [2][TAPS];
  int unsigned                head_pos [2];
  logic [1:0]                 channel_count_cfg;

  fir_req_t pending_requests[$];
  fir_res_t expected_outputs[$];

  fir_req_t    tx_current;
  int unsigned tx_idle;
  int unsigned rx_wait;
  int unsigned rx_hold_left;
  int unsigned rx_hold_len;
  int unsigned rx_hold_seq;
  int unsigned rx_hold_seen;
  bit          quiet_mode;
  int unsigned fail_count;
  longint      cycle_count;

  // Filters one accepted request and queues the result that it should give.
  task automatic filter_request(input fir_req_t r);
    int unsigned ch;
    int unsigned pos;
    int unsigned j;
    longint      acc;
    longint      y;
    logic        mono;
    fir_res_t    res;
    if (r.func == FUNC_LOAD) begin
      if (r.tap_index < TAPS) tap_coef[r.tap_index] = r.tap_value;
      return;
    end
    // A count of zero behaves as mono, three as stereo.
    mono = (channel_count_cfg <= CH_COUNT_MONO);
    ch   = r.channel;
    if (mono && ch == 1) return;
    pos = head_pos[ch];
    history[ch][pos] = r.sample_in;
    acc = 0;
    j   = pos;
    for (int k = 0; k < TAPS; k++) begin
      acc += longint'(tap_coef[k]) * longint'(history[ch][j]);
      j = (j == 0) ? TAPS - 1 : j - 1;
    end
    head_pos[ch] = (pos + 1) % TAPS;
    // Round half up, then clip to the sample range.
    y = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    res.saturated = 1'b0;
    if (y > longint'(SAMPLE_MAX)) begin
      y = longint'(SAMPLE_MAX);
      res.saturated = 1'b1;
    end else if (y < longint'(SAMPLE_MIN)) begin
      y = longint'(SAMPLE_MIN);
      res.saturated = 1'b1;
    end
    res.channel_out  = r.channel;
    res.sample_out   = y[23:0];
    res.copy_to_both = mono;
    expected_outputs.push_back(res);
  endtask

  // Random value whose magnitude spans a random number of bits, up to width.
  function automatic logic signed [31:0] rand_wide(int unsigned width);
    int unsigned        bits;
    logic signed [31:0] raw;
    bits = $urandom_range(1, width);
    raw  = $urandom;
    return raw >>> (32 - bits);
  endfunction

  // Idle cycles before the next request on either side.
  function automatic int unsigned draw_idle();
    if (quiet_mode || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic void push_sample(logic ch, logic signed [23:0] value);
    fir_req_t r;
    r.func      = FUNC_SAMPLE;
    r.channel   = ch;
    r.sample_in = value;
    r.tap_index = 9'($urandom);
    r.tap_value = 18'($urandom);
    pending_requests.push_back(r);
  endfunction

  function automatic void push_load(logic [8:0] idx, logic signed [17:0] value);
    fir_req_t r;
    r.func      = FUNC_LOAD;
    r.channel   = 1'($urandom);
    r.sample_in = 24'($urandom);
    r.tap_index = idx;
    r.tap_value = value;
    pending_requests.push_back(r);
  endfunction

  // Mostly samples on the left channel, so its delay line wraps during the run.
  function automatic void queue_random_phase(int count);
    logic signed [17:0] coef;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        coef = ($urandom_range(0, 4) == 0) ? 18'sd0 : 18'(rand_wide(18));
        push_load(9'($urandom_range(0, 1) ? $urandom_range(0, 511) : $urandom_range(0, 15)),
                  coef);
      end else begin
        push_sample($urandom_range(0, 9) < 7 ? 1'b0 : 1'b1, 24'(rand_wide(24)));
      end
    end
  endfunction

  // Waits until every request is taken and answered, then lets the block settle.
  task automatic wait_until_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || req_if.valid || expected_outputs.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_channel_count(logic [1:0] value);
    wait_until_idle();
    cfg_we            <= 1'b1;
    cfg_wdata         <= value;
    channel_count_cfg = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Request driver: holds each request until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      tx_idle      = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        filter_request(tx_current);
        tx_idle = draw_idle();
      end
      if (!req_if.valid || req_if.ready) begin
        if (tx_idle > 0) begin
          tx_idle--;
          req_if.valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          tx_current = pending_requests.pop_front();
          req_if.valid     <= 1'b1;
          req_if.func      <= tx_current.func;
          req_if.channel   <= tx_current.channel;
          req_if.sample_in <= tx_current.sample_in;
          req_if.tap_index <= tx_current.tap_index;
          req_if.tap_value <= tx_current.tap_value;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk) begin
    fir_res_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
      rx_wait      = draw_idle();
      rx_hold_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_outputs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result ch=%0d sample=%0d copy=%0b sat=%0b", $realtime,
                     res_if.channel_out, res_if.sample_out, res_if.copy_to_both,
                     res_if.saturated);
        end else begin
          want = expected_outputs.pop_front();
          if (res_if.channel_out !== want.channel_out || res_if.sample_out !== want.sample_out
              || res_if.copy_to_both !== want.copy_to_both
              || res_if.saturated !== want.saturated) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch expected ch=%0d sample=%0d copy=%0b sat=%0b, got ch=%0d sample=%0d copy=%0b sat=%0b",
                       $realtime, want.channel_out, want.sample_out, want.copy_to_both,
                       want.saturated, res_if.channel_out, res_if.sample_out,
                       res_if.copy_to_both, res_if.saturated);
          end
        end
        rx_wait = draw_idle();
      end
      if (rx_hold_seq != rx_hold_seen) begin
        rx_hold_seen = rx_hold_seq;
        rx_hold_left = rx_hold_len;
      end
      // The long stall counts every cycle; the per-result wait only counts
      // while a result is on offer.
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        res_if.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        if (res_if.valid) rx_wait--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the length of the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_if.valid     = 1'b0;
    req_if.func      = FUNC_SAMPLE;
    req_if.channel   = 1'b0;
    req_if.sample_in = '0;
    req_if.tap_index = '0;
    req_if.tap_value = '0;
    res_if.ready     = 1'b0;
    quiet_mode       = 1'b0;
    rx_hold_len      = 0;
    rx_hold_seq      = 0;
    rx_hold_seen     = 0;
    fail_count       = 0;
    cycle_count      = 0;
    channel_count_cfg = CH_COUNT_RESET;
    head_pos[0]      = 0;
    head_pos[1]      = 0;
    for (int k = 0; k < TAPS; k++) begin
      tap_coef[k]   = '0;
      history[0][k] = '0;
      history[1][k] = '0;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, stereo from reset. Zero taps give silence even at full scale.
    push_sample(1'b0, SAMPLE_MAX);
    push_sample(1'b1, SAMPLE_MIN);
    // A half tap shows rounding of ties toward positive infinity.
    push_load(9'd0, 18'sd65536);
    push_sample(1'b1, 24'sd1);
    push_sample(1'b1, -24'sd1);
    push_sample(1'b1, 24'sd3);
    // Extreme taps drive the sum into saturation in both directions.
    push_load(9'd0, 18'sd131071);
    push_load(9'd1, -18'sd131072);
    push_load(9'd511, 18'sd43981);
    push_sample(1'b0, SAMPLE_MIN);
    push_sample(1'b0, SAMPLE_MAX);
    push_load(9'd1, 18'sd0);
    push_sample(1'b0, SAMPLE_MIN);

    // Mono: right channel samples vanish and left results are copied.
    set_channel_count(2'd1);
    push_sample(1'b1, 24'sd5);
    push_sample(1'b0, 24'sd100);
    // A count of zero also means mono.
    set_channel_count(2'd0);
    push_sample(1'b1, 24'sd7);
    push_sample(1'b0, -24'sd100);
    // A count of three means stereo.
    set_channel_count(2'd3);
    push_sample(1'b1, 24'sd12345);
    push_sample(1'b0, -24'sd1);

    // Random part: back-to-back traffic first, then random gaps.
    set_channel_count(2'd2);
    quiet_mode = 1'b1;
    queue_random_phase(PHASE_ITEMS);

    set_channel_count(2'd1);
    quiet_mode = 1'b0;
    queue_random_phase(PHASE_ITEMS);

    // Long receiver stall while requests keep coming, so the block backs up.
    set_channel_count(2'd3);
    rx_hold_len = LONG_HOLD;
    rx_hold_seq++;
    queue_random_phase(PHASE_ITEMS);

    set_channel_count(2'd0);
    queue_random_phase(PHASE_ITEMS);

    set_channel_count(2'd2);
    queue_random_phase(PHASE_ITEMS);

    wait_until_idle();
    if (fail_count == 0 && expected_outputs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
